// ===== hdl/gws_pkg.sv =====
package gws_pkg;

    localparam int MAX_CELLS = 16;
    localparam int MAX_WORD  = 16;

    localparam int CELL_W  = $clog2(MAX_CELLS);
    localparam int NCELL_W = $clog2(MAX_CELLS + 1);
    localparam int WIDX_W  = $clog2(MAX_WORD);
    localparam int WLEN_W  = $clog2(MAX_WORD + 2);
    localparam int DIM_W   = 5;
    localparam int RC_W    = DIM_W - 1;
    localparam int NB_W    = ((CELL_W > DIM_W) ? CELL_W : DIM_W) + 1;
    localparam int CHAR_W  = 8;
    localparam int UPC_W   = 4;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic {
        REQ_GRID = 1'b0,
        REQ_WORD = 1'b1
    } t_req;

    typedef enum logic {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIR_UP    = 3'd0,
        DIR_DOWN  = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_RIGHT = 3'd3,
        DIR_DONE  = 3'd4
    } t_dir;

    typedef enum logic [3:0] {
        U_NOP,
        U_INIT,
        U_PUSH_START,
        U_STEP,
        U_PUSH_NB,
        U_POP,
        U_ADV_START,
        U_EMIT_FAIL,
        U_EMIT_PASS
    } t_uop;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_SEARCH,
        C_BAD_LEN,
        C_LETTER_MISS,
        C_LEN_ONE,
        C_DEPTH_ZERO,
        C_DIR_DONE,
        C_NB_MISS,
        C_DEPTH_LAST,
        C_MORE_STARTS
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        logic  gsel_nb;
        t_upc  target;
    } t_uword;

    localparam t_upc P_IDLE  = 4'd0;
    localparam t_upc P_CHECK = 4'd1;
    localparam t_upc P_START = 4'd2;
    localparam t_upc P_ONE   = 4'd3;
    localparam t_upc P_ROOT  = 4'd4;
    localparam t_upc P_LOOP  = 4'd5;
    localparam t_upc P_DIRS  = 4'd6;
    localparam t_upc P_STEP  = 4'd7;
    localparam t_upc P_TEST  = 4'd8;
    localparam t_upc P_LAST  = 4'd9;
    localparam t_upc P_PUSH  = 4'd10;
    localparam t_upc P_POP   = 4'd11;
    localparam t_upc P_NEXT  = 4'd12;
    localparam t_upc P_FAIL  = 4'd13;
    localparam t_upc P_PASS  = 4'd14;

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w = '{op: U_NOP, cond: C_ALWAYS, gsel_nb: 1'b0, target: P_IDLE};
        unique case (pc)
            P_IDLE:  w = '{op: U_NOP,        cond: C_NO_SEARCH,   gsel_nb: 1'b0, target: P_IDLE};
            P_CHECK: w = '{op: U_INIT,       cond: C_BAD_LEN,     gsel_nb: 1'b0, target: P_FAIL};
            P_START: w = '{op: U_NOP,        cond: C_LETTER_MISS, gsel_nb: 1'b0, target: P_NEXT};
            P_ONE:   w = '{op: U_NOP,        cond: C_LEN_ONE,     gsel_nb: 1'b0, target: P_PASS};
            P_ROOT:  w = '{op: U_PUSH_START, cond: C_NEVER,       gsel_nb: 1'b0, target: P_IDLE};
            P_LOOP:  w = '{op: U_NOP,        cond: C_DEPTH_ZERO,  gsel_nb: 1'b0, target: P_NEXT};
            P_DIRS:  w = '{op: U_NOP,        cond: C_DIR_DONE,    gsel_nb: 1'b0, target: P_POP};
            P_STEP:  w = '{op: U_STEP,       cond: C_NEVER,       gsel_nb: 1'b0, target: P_IDLE};
            P_TEST:  w = '{op: U_NOP,        cond: C_NB_MISS,     gsel_nb: 1'b1, target: P_LOOP};
            P_LAST:  w = '{op: U_NOP,        cond: C_DEPTH_LAST,  gsel_nb: 1'b0, target: P_PASS};
            P_PUSH:  w = '{op: U_PUSH_NB,    cond: C_ALWAYS,      gsel_nb: 1'b0, target: P_LOOP};
            P_POP:   w = '{op: U_POP,        cond: C_ALWAYS,      gsel_nb: 1'b0, target: P_LOOP};
            P_NEXT:  w = '{op: U_ADV_START,  cond: C_MORE_STARTS, gsel_nb: 1'b0, target: P_START};
            P_FAIL:  w = '{op: U_EMIT_FAIL,  cond: C_ALWAYS,      gsel_nb: 1'b0, target: P_IDLE};
            P_PASS:  w = '{op: U_EMIT_PASS,  cond: C_ALWAYS,      gsel_nb: 1'b0, target: P_IDLE};
            default: w = '{op: U_NOP,        cond: C_ALWAYS,      gsel_nb: 1'b0, target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/grid_word_search.sv =====
// Letter-grid word search with a four-neighbour, no-reuse path rule.
// Input channel: a request is accepted when i_start is high and o_busy is low.
// i_req_type selects a grid cell write (i_cell_index, i_char_value) or a
// word character append (i_char_value); i_last on a word character starts
// the search. Grid writes and non-final characters leave the block ready at
// once.
// Result channel: o_found_valid pulses for one cycle with o_found. It comes
// only after a final word character; the receiver cannot stall it.
// Search: o_busy is high from the cycle after the final character until the
// o_found_valid pulse, which comes in the same cycle that o_busy falls. An
// empty word, one that is too long or one longer than the grid goes from the
// length check straight to a fail result. Otherwise the one-step-per-cycle
// microcode sequencer tries each start cell: it skips one whose letter differs,
// pushes a match, tests the four neighbours of the top cell, pushes one that
// fits and pops when all are tried; it passes on a full word, else fails.
// Configuration: i_cfg_index 0 sets rows, 1 sets columns; taken when
// i_cfg_valid and o_cfg_ready are high, ready only while idle.
// Reset: synchronous active-low i_rst_n returns to idle with a 4 by 4 grid,
// an empty word and no pending result. Grid letters are undefined until
// written.
module grid_word_search
    import gws_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_req_type,
    input  logic [CELL_W-1:0]   i_cell_index,
    input  logic [CHAR_W-1:0]   i_char_value,
    input  logic                i_last,
    output logic                o_found,
    output logic                o_found_valid,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [DIM_W-1:0]    i_cfg_data
);

    t_upc                r_pc, n_pc;
    t_uword              cw;
    logic                cond_true;

    logic [DIM_W-1:0]    r_rows, r_cols;
    logic [CHAR_W-1:0]   r_grid [MAX_CELLS];
    logic [CHAR_W-1:0]   r_word [MAX_WORD];
    logic [WLEN_W-1:0]   r_wlen;
    logic [MAX_CELLS-1:0] r_used;

    logic [CELL_W-1:0]   r_pcell [MAX_WORD];
    logic [RC_W-1:0]     r_prow  [MAX_WORD];
    logic [RC_W-1:0]     r_pcol  [MAX_WORD];
    t_dir                r_pdir  [MAX_WORD];
    logic [WIDX_W-1:0]   r_depth;

    logic [CELL_W-1:0]   r_start;
    logic [RC_W-1:0]     r_srow, r_scol;

    logic [CELL_W-1:0]   r_nb_cell;
    logic [RC_W-1:0]     r_nb_row, r_nb_col;
    logic                r_nb_ok;

    logic                r_found, r_found_valid;

    logic                accept;
    logic [2*DIM_W-1:0]  prod;
    logic [NCELL_W-1:0]  ncells;
    logic [WIDX_W-1:0]   top;
    logic [CELL_W-1:0]   gaddr;
    logic                letter_eq;
    logic                nb_exists;
    logic [NB_W-1:0]     nb_sum;
    logic [RC_W-1:0]     nb_row, nb_col;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_pc != P_IDLE);
    assign o_cfg_ready = !o_busy;
    assign o_found       = r_found;
    assign o_found_valid = r_found_valid;

    assign prod   = r_rows * r_cols;
    assign ncells = (prod > (2*DIM_W)'(MAX_CELLS)) ? NCELL_W'(MAX_CELLS) : prod[NCELL_W-1:0];

    assign top       = r_depth - WIDX_W'(1);
    assign gaddr     = cw.gsel_nb ? r_nb_cell : r_start;
    assign letter_eq = (r_grid[gaddr] == r_word[r_depth]);

    always_comb begin
        nb_exists = 1'b0;
        nb_sum    = NB_W'(r_pcell[top]);
        nb_row    = r_prow[top];
        nb_col    = r_pcol[top];
        case (r_pdir[top])
            DIR_UP: begin
                nb_exists = (r_prow[top] != '0);
                nb_sum    = NB_W'(r_pcell[top]) - NB_W'(r_cols);
                nb_row    = r_prow[top] - RC_W'(1);
            end
            DIR_DOWN: begin
                nb_exists = ((DIM_W'(r_prow[top]) + DIM_W'(1)) < r_rows);
                nb_sum    = NB_W'(r_pcell[top]) + NB_W'(r_cols);
                nb_row    = r_prow[top] + RC_W'(1);
            end
            DIR_LEFT: begin
                nb_exists = (r_pcol[top] != '0);
                nb_sum    = NB_W'(r_pcell[top]) - NB_W'(1);
                nb_col    = r_pcol[top] - RC_W'(1);
            end
            DIR_RIGHT: begin
                nb_exists = ((DIM_W'(r_pcol[top]) + DIM_W'(1)) < r_cols);
                nb_sum    = NB_W'(r_pcell[top]) + NB_W'(1);
                nb_col    = r_pcol[top] + RC_W'(1);
            end
            default: begin
                nb_exists = 1'b0;
            end
        endcase
        nb_exists = nb_exists && (nb_sum < NB_W'(ncells));
    end

    always_comb begin
        cw = ucode(r_pc);
        cond_true = 1'b0;
        case (cw.cond)
            C_NEVER:       cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_NO_SEARCH:   cond_true = !(accept && (i_req_type == REQ_WORD) && i_last);
            C_BAD_LEN:     cond_true = (r_wlen == '0) || (r_wlen > WLEN_W'(MAX_WORD))
                                       || (WLEN_W'(r_wlen) > WLEN_W'(ncells));
            C_LETTER_MISS: cond_true = !letter_eq;
            C_LEN_ONE:     cond_true = (r_wlen == WLEN_W'(1));
            C_DEPTH_ZERO:  cond_true = (r_depth == '0);
            C_DIR_DONE:    cond_true = (r_pdir[top] == DIR_DONE);
            C_NB_MISS:     cond_true = !r_nb_ok || r_used[r_nb_cell] || !letter_eq;
            C_DEPTH_LAST:  cond_true = ((WLEN_W'(r_depth) + WLEN_W'(1)) == r_wlen);
            C_MORE_STARTS: cond_true = ((NCELL_W'(r_start) + NCELL_W'(1)) < ncells);
            default:       cond_true = 1'b0;
        endcase
        n_pc = cond_true ? cw.target : r_pc + t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_W'(4);
            r_cols <= DIM_W'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end else begin
                r_cols <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_req_type == REQ_GRID)) begin
            r_grid[i_cell_index] <= i_char_value;
        end
        if (accept && (i_req_type == REQ_WORD) && (r_wlen < WLEN_W'(MAX_WORD))) begin
            r_word[r_wlen[WIDX_W-1:0]] <= i_char_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen        <= '0;
            r_used        <= '0;
            r_depth       <= '0;
            r_found_valid <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            r_found_valid <= 1'b0;
            if (accept && (i_req_type == REQ_WORD) && (r_wlen <= WLEN_W'(MAX_WORD))) begin
                r_wlen <= r_wlen + WLEN_W'(1);
            end
            case (cw.op)
                U_INIT: begin
                    r_used  <= '0;
                    r_depth <= '0;
                end
                U_PUSH_START: begin
                    r_used[r_start] <= 1'b1;
                    r_depth         <= WIDX_W'(1);
                end
                U_PUSH_NB: begin
                    r_used[r_nb_cell] <= 1'b1;
                    r_depth           <= r_depth + WIDX_W'(1);
                end
                U_POP: begin
                    r_used[r_pcell[top]] <= 1'b0;
                    r_depth              <= top;
                end
                U_EMIT_FAIL, U_EMIT_PASS: begin
                    r_used        <= '0;
                    r_wlen        <= '0;
                    r_found_valid <= 1'b1;
                    r_found       <= (cw.op == U_EMIT_PASS);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (cw.op)
            U_INIT: begin
                r_start <= '0;
                r_srow  <= '0;
                r_scol  <= '0;
            end
            U_ADV_START: begin
                r_start <= r_start + CELL_W'(1);
                if ((DIM_W'(r_scol) + DIM_W'(1)) == r_cols) begin
                    r_scol <= '0;
                    r_srow <= r_srow + RC_W'(1);
                end else begin
                    r_scol <= r_scol + RC_W'(1);
                end
            end
            U_PUSH_START: begin
                r_pcell[0] <= r_start;
                r_prow[0]  <= r_srow;
                r_pcol[0]  <= r_scol;
                r_pdir[0]  <= DIR_UP;
            end
            U_STEP: begin
                r_nb_cell   <= nb_sum[CELL_W-1:0];
                r_nb_row    <= nb_row;
                r_nb_col    <= nb_col;
                r_nb_ok     <= nb_exists;
                r_pdir[top] <= t_dir'(r_pdir[top] + 3'd1);
            end
            U_PUSH_NB: begin
                r_pcell[r_depth] <= r_nb_cell;
                r_prow[r_depth]  <= r_nb_row;
                r_pcol[r_depth]  <= r_nb_col;
                r_pdir[r_depth]  <= DIR_UP;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/gws_checker.sv =====
module gws_checker
    import gws_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic i_req_type,
    input logic i_last,
    input logic o_found_valid,
    input logic o_cfg_ready
);

    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found_valid |=> !o_found_valid)
        else $error("result strobe longer than one cycle");

    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req_type == REQ_WORD) && i_last) |=> o_busy)
        else $error("final character did not start a search");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !((i_req_type == REQ_WORD) && i_last)) |=> !o_busy)
        else $error("load word left the block busy");

    a_result_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found_valid |-> (!o_busy && o_cfg_ready && $past(o_busy)))
        else $error("result outside the end of a search");

endmodule

bind grid_word_search gws_checker u_gws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .i_req_type    (i_req_type),
    .i_last        (i_last),
    .o_found_valid (o_found_valid),
    .o_cfg_ready   (o_cfg_ready)
);

// ===== tb/sv/grid_word_search_tb.sv =====
`timescale 1ns / 100ps

module grid_word_search_tb;
    import gws_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 24;

    typedef struct packed {
        t_req                kind;
        logic [CELL_W-1:0]   slot;
        logic [CHAR_W-1:0]   ch;
        logic                last;
    } t_req_word;

    logic                i_clk;
    logic                i_rst_n      = 1'b0;
    logic                i_start      = 1'b0;
    logic                i_req_type   = 1'b0;
    logic [CELL_W-1:0]   i_cell_index = '0;
    logic [CHAR_W-1:0]   i_char_value = '0;
    logic                i_last       = 1'b0;
    logic                i_cfg_valid  = 1'b0;
    logic                i_cfg_index  = 1'b0;
    logic [DIM_W-1:0]    i_cfg_data   = '0;
    logic                o_busy;
    logic                o_found;
    logic                o_found_valid;
    logic                o_cfg_ready;

    t_req_word           req_words[$];
    t_req_word           cur;
    bit                  found_due[$];
    bit                  expected_found;

    logic [CHAR_W-1:0]   grid_now[MAX_CELLS];
    logic [CHAR_W-1:0]   word_now[MAX_WORD];
    int                  word_cnt = 0;
    int                  dim_rows = 4;
    int                  dim_cols = 4;

    logic [CHAR_W-1:0]   plan_grid[MAX_CELLS];
    int                  alpha_base = 65;
    int                  alpha_size = 4;
    int                  queued_cnt = 0;

    int                  accepted_cnt = 0;
    int                  search_cnt   = 0;
    int                  hit_cnt      = 0;
    int                  cfg_writes   = 0;
    int                  errors       = 0;
    int                  cycle_cnt    = 0;

    grid_word_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_req_type    (i_req_type),
        .i_cell_index  (i_cell_index),
        .i_char_value  (i_char_value),
        .i_last        (i_last),
        .o_found       (o_found),
        .o_found_valid (o_found_valid),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int neighbour_of(input int at, input int dir, input int span);
        int nb;
        nb = -1;
        case (dir)
            int'(DIR_UP):    if (at / dim_cols > 0) nb = at - dim_cols;
            int'(DIR_DOWN):  if (at / dim_cols + 1 < dim_rows) nb = at + dim_cols;
            int'(DIR_LEFT):  if (at % dim_cols > 0) nb = at - 1;
            int'(DIR_RIGHT): if (at % dim_cols + 1 < dim_cols) nb = at + 1;
            default:         nb = -1;
        endcase
        if (nb >= span) nb = -1;
        return nb;
    endfunction

    function automatic bit word_traceable();
        int                    span;
        int                    start_at;
        int                    top;
        int                    k;
        int                    nb;
        int                    trail[MAX_WORD];
        int                    tried[MAX_WORD];
        logic [MAX_CELLS-1:0]  taken;
        span = dim_rows * dim_cols;
        if (span > MAX_CELLS) span = MAX_CELLS;
        if (word_cnt == 0 || word_cnt > MAX_WORD || word_cnt > span) return 1'b0;
        for (start_at = 0; start_at < span; start_at++) begin
            if (grid_now[start_at] == word_now[0]) begin
                if (word_cnt == 1) return 1'b1;
                trail[0] = start_at;
                tried[0] = int'(DIR_UP);
                taken = '0;
                taken[start_at] = 1'b1;
                top = 1;
                while (top > 0) begin
                    k = top - 1;
                    if (tried[k] >= int'(DIR_DONE)) begin
                        taken[trail[k]] = 1'b0;
                        top--;
                    end else begin
                        nb = neighbour_of(trail[k], tried[k], span);
                        tried[k]++;
                        if (nb >= 0 && !taken[nb] && grid_now[nb] == word_now[top]) begin
                            if (top + 1 == word_cnt) return 1'b1;
                            trail[top] = nb;
                            tried[top] = int'(DIR_UP);
                            taken[nb] = 1'b1;
                            top++;
                        end
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_letter();
        if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom_range(0, 255));
        return CHAR_W'(alpha_base + $urandom_range(0, alpha_size - 1));
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 1;
        if (r < 40) return 16;
        return $urandom_range(1, 16);
    endfunction

    task automatic push_cell(input int idx, input logic [CHAR_W-1:0] ch, input logic last);
        t_req_word w;
        w.kind = REQ_GRID;
        w.slot = CELL_W'(idx);
        w.ch   = ch;
        w.last = last;
        plan_grid[idx] = ch;
        req_words.push_back(w);
        queued_cnt++;
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
        t_req_word w;
        w.kind = REQ_WORD;
        w.slot = CELL_W'($urandom_range(0, MAX_CELLS - 1));
        w.ch   = ch;
        w.last = last;
        req_words.push_back(w);
        queued_cnt++;
    endtask

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) push_char(s[k], k == s.len() - 1);
    endtask

    task automatic write_dim(input t_cfg_idx which, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= DIM_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (which == CFG_ROWS) dim_rows = value;
        else dim_cols = value;
        cfg_writes++;
    endtask

    task automatic drain();
        while (req_words.size() != 0 || i_start || found_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic queue_phase(input int quota);
        int                    span;
        int                    stop_at;
        int                    pick;
        int                    here;
        int                    target;
        int                    nb;
        int                    d;
        int                    k;
        int                    put_at;
        int                    cand[$];
        logic [CHAR_W-1:0]     letters[$];
        logic [MAX_CELLS-1:0]  visited;
        span = dim_rows * dim_cols;
        if (span > MAX_CELLS) span = MAX_CELLS;
        stop_at = queued_cnt + quota;
        alpha_base = $urandom_range(0, 255);
        alpha_size = $urandom_range(3, 6);
        repeat ($urandom_range(4, 16))
            push_cell($urandom_range(0, MAX_CELLS - 1), pick_letter(),
                      1'($urandom_range(0, 1)));
        while (queued_cnt < stop_at) begin
            pick = $urandom_range(0, 99);
            letters.delete();
            if (pick < 14) begin
                push_cell($urandom_range(0, MAX_CELLS - 1), pick_letter(),
                          1'($urandom_range(0, 1)));
            end else begin
                if (pick < 74) begin
                    here = $urandom_range(0, span - 1);
                    visited = '0;
                    visited[here] = 1'b1;
                    letters.push_back(plan_grid[here]);
                    target = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_WORD)
                                                         : $urandom_range(1, 7);
                    while (letters.size() < target) begin
                        cand.delete();
                        for (d = int'(DIR_UP); d < int'(DIR_DONE); d++) begin
                            nb = neighbour_of(here, d, span);
                            if (nb >= 0 && !visited[nb]) cand.push_back(nb);
                        end
                        if (cand.size() == 0) break;
                        here = cand[$urandom_range(0, cand.size() - 1)];
                        visited[here] = 1'b1;
                        letters.push_back(plan_grid[here]);
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        k = $urandom_range(0, 2);
                        if (k == 0) letters[$urandom_range(0, letters.size() - 1)] = pick_letter();
                        else if (k == 1) letters.push_back(pick_letter());
                        else if (letters.size() > 1) void'(letters.pop_front());
                    end
                end else if (pick < 96) begin
                    repeat ($urandom_range(1, 5)) letters.push_back(pick_letter());
                end else begin
                    repeat ($urandom_range(MAX_WORD + 1, MAX_WORD + 4))
                        letters.push_back(pick_letter());
                end
                put_at = -1;
                if (letters.size() > 1 && $urandom_range(0, 9) == 0)
                    put_at = $urandom_range(1, letters.size() - 1);
                for (k = 0; k < letters.size(); k++) begin
                    if (k == put_at)
                        push_cell($urandom_range(0, MAX_CELLS - 1), pick_letter(), 1'b0);
                    push_char(letters[k], k == letters.size() - 1);
                end
            end
        end
    endtask

    // drop idling for a long stretch in the middle of the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || !o_busy) begin
            if (req_words.size() != 0 &&
                ((accepted_cnt >= 500 && accepted_cnt < 760) || $urandom_range(0, 99) >= 24)) begin
                cur = req_words.pop_front();
                i_start      <= 1'b1;
                i_req_type   <= cur.kind;
                i_cell_index <= cur.slot;
                i_char_value <= cur.ch;
                i_last       <= cur.last;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) begin
            accepted_cnt++;
            if (t_req'(i_req_type) == REQ_GRID) begin
                grid_now[i_cell_index] = i_char_value;
            end else begin
                if (word_cnt < MAX_WORD) word_now[word_cnt] = i_char_value;
                if (word_cnt <= MAX_WORD) word_cnt++;
                if (i_last) begin
                    found_due.push_back(word_traceable());
                    word_cnt = 0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_found_valid !== 1'b0) begin
            search_cnt++;
            if (o_found === 1'b1) hit_cnt++;
            if (o_found_valid !== 1'b1) begin
                $display("%0t: found strobe expected 0 or 1, actual %b", $time, o_found_valid);
                errors++;
            end else if (found_due.size() == 0) begin
                $display("%0t: found expected none, actual %b", $time, o_found);
                errors++;
            end else begin
                expected_found = found_due.pop_front();
                if (o_found !== expected_found) begin
                    $display("%0t: found expected %b, actual %b", $time, expected_found, o_found);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, found_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int    k;
        string seed_text;
        seed_text = "CATSOXDOGENGZ";
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < 13; k++) push_cell(k, seed_text[k], 1'b0);
        push_cell(13, 8'h00, 1'b0);
        push_cell(14, 8'hFF, 1'b0);
        push_cell(15, "Q", 1'b1);
        push_text("CAT");
        push_text("ACA");
        push_char("E", 1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b1);
        push_text("Q");
        drain();

        write_dim(CFG_ROWS, 2);
        write_dim(CFG_COLS, 2);
        push_text("CAST");
        push_text("CATSC");
        drain();
        write_dim(CFG_COLS, 0);
        push_text("C");
        drain();
        write_dim(CFG_ROWS, 1);
        write_dim(CFG_COLS, 16);
        push_text("SOX");
        drain();
        write_dim(CFG_ROWS, 16);
        write_dim(CFG_COLS, 1);
        push_text("TS");
        drain();
        write_dim(CFG_COLS, 16);
        push_text("GZ");
        drain();

        while (queued_cnt < ITEM_TARGET) begin
            write_dim(CFG_ROWS, pick_dim());
            write_dim(CFG_COLS, pick_dim());
            queue_phase($urandom_range(40, 110));
            drain();
        end

        $display("Accepted %0d requests over %0d register writes to the grid shape.",
                 accepted_cnt, cfg_writes);
        $display("Checked %0d searches, %0d of them found a path.", search_cnt, hit_cnt);
        if (errors == 0 && found_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== grid_word_search.f =====
hdl/gws_pkg.sv
hdl/grid_word_search.sv
hdl/gws_checker.sv
tb/sv/grid_word_search_tb.sv
